// ----- hw/rtl/w2s_pkg.sv -----
// ----------------------------------------------------------------------------
// w2s_pkg
// Shared constants, types and helpers of the world to screen projection.
// ----------------------------------------------------------------------------
package w2s_pkg;

  localparam int FRAC_BITS = 16;

  localparam int DATA_W  = 32;
  localparam int PROD_W  = 2 * DATA_W;
  localparam int ACC_W   = PROD_W;
  localparam int WIN_W   = 14;
  localparam int HALF_W  = WIN_W - 1;
  localparam int COEF_N  = 16;
  localparam int COEF_IW = $clog2(COEF_N);

  // one in fixed point, used to pass the translation column through the multiplier
  localparam logic signed [DATA_W-1:0] ONE_Q = DATA_W'(64'sd1 <<< FRAC_BITS);

  // 0.1 rounded to nearest
  localparam logic signed [ACC_W-1:0] THRESH =
    ACC_W'(((64'sd1 <<< FRAC_BITS) + 64'sd5) / 64'sd10);

  localparam logic signed [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  localparam logic [WIN_W-1:0] WIDTH_RST  = WIN_W'(1920);
  localparam logic [WIN_W-1:0] HEIGHT_RST = WIN_W'(1080);

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_PROJECT = 1'b1;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_CLEAR,
    ACC_ADD_SHR,
    ACC_LOAD_SUM
  } acc_op_t;

  typedef struct packed {
    logic    mul_en;
    acc_op_t op;
  } mac_ctl_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'(Q_MAX);
    lo = ACC_W'(Q_MIN);
    if (v > hi) begin
      return Q_MAX;
    end else if (v < lo) begin
      return Q_MIN;
    end
    return v[DATA_W-1:0];
  endfunction

endpackage

// ----- hw/rtl/w2s_mac.sv -----
// ----------------------------------------------------------------------------
// w2s_mac
// Shared signed multiplier with a registered product and a wide accumulator.
// ----------------------------------------------------------------------------
module w2s_mac (
  input  logic                                 clk,
  input  w2s_pkg::mac_ctl_t                    ctl,
  input  logic signed [w2s_pkg::DATA_W-1:0]    a,
  input  logic signed [w2s_pkg::DATA_W-1:0]    b,
  input  logic signed [w2s_pkg::ACC_W-1:0]     k,
  output logic signed [w2s_pkg::ACC_W-1:0]     acc
);

  logic signed [w2s_pkg::PROD_W-1:0] prod;

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod <= a * b;
    end
    case (ctl.op)
      w2s_pkg::ACC_HOLD:     acc <= acc;
      w2s_pkg::ACC_CLEAR:    acc <= '0;
      // floor shift of the product back to the fixed point scale
      w2s_pkg::ACC_ADD_SHR:  acc <= acc + w2s_pkg::ACC_W'(prod >>> w2s_pkg::FRAC_BITS);
      w2s_pkg::ACC_LOAD_SUM: acc <= w2s_pkg::ACC_W'(prod) + k;
      default:               acc <= acc;
    endcase
  end

endmodule

// ----- hw/rtl/w2s_div.sv -----
// ----------------------------------------------------------------------------
// w2s_div
// Bit-serial restoring divider giving a saturated signed fixed point quotient.
// ----------------------------------------------------------------------------
module w2s_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [w2s_pkg::ACC_W-1:0]   num,
  input  logic signed [w2s_pkg::ACC_W-1:0]   den,
  output logic                               done,
  output logic signed [w2s_pkg::DATA_W-1:0]  quot
);

  localparam int AW = w2s_pkg::ACC_W;
  localparam int QW = w2s_pkg::DATA_W - 1;
  localparam int NW = AW + QW;
  localparam int CW = $clog2(QW);

  typedef enum logic [2:0] {
    D_IDLE,
    D_CHK,
    D_RUN,
    D_SIGN,
    D_FIN
  } dstate_t;

  dstate_t         state;
  logic            neg;
  logic [AW-1:0]   mag;
  logic [AW-1:0]   d;
  logic [AW-1:0]   rem;
  logic [QW-1:0]   low;
  logic [QW-1:0]   q;
  logic [CW-1:0]   cnt;

  logic [NW-1:0]   n_ext;
  logic [NW-1:0]   d_ext;
  logic [AW:0]     diff;

  always_comb begin
    n_ext = NW'(mag) << w2s_pkg::FRAC_BITS;
    d_ext = {d, {QW{1'b0}}};
    diff  = {rem, low[QW-1]} - {1'b0, d};
  end

  assign done = (state == D_FIN);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
    end else begin
      case (state)
        D_IDLE: begin
          if (start) begin
            neg   <= num[AW-1];
            mag   <= num[AW-1] ? AW'(-num) : AW'(num);
            d     <= AW'(den);
            state <= D_CHK;
          end
        end
        D_CHK: begin
          // quotient of 2^31 or more saturates
          if (n_ext >= d_ext) begin
            quot  <= neg ? w2s_pkg::Q_MIN : w2s_pkg::Q_MAX;
            state <= D_FIN;
          end else begin
            rem   <= n_ext[NW-1:QW];
            low   <= n_ext[QW-1:0];
            q     <= '0;
            cnt   <= '0;
            state <= D_RUN;
          end
        end
        D_RUN: begin
          if (!diff[AW]) begin
            rem <= diff[AW-1:0];
            q   <= {q[QW-2:0], 1'b1};
          end else begin
            rem <= {rem[AW-2:0], low[QW-1]};
            q   <= {q[QW-2:0], 1'b0};
          end
          low <= {low[QW-2:0], 1'b0};
          cnt <= cnt + CW'(1);
          if (cnt == CW'(QW - 1)) begin
            state <= D_SIGN;
          end
        end
        D_SIGN: begin
          quot  <= neg ? -{1'b0, q} : {1'b0, q};
          state <= D_FIN;
        end
        D_FIN: begin
          state <= D_IDLE;
        end
        default: state <= D_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/world_to_screen_projection.sv -----
// ----------------------------------------------------------------------------
// world_to_screen_projection
// Fixed point 4x4 matrix projection of a world point to screen coordinates.
// ----------------------------------------------------------------------------
//  channel  signals                                       direction
//  in       in_valid in_ready operation coef_index        into block
//           coef_value pos_x pos_y pos_z
//  out      out_valid out_ready visible screen_x screen_y from block
//  cfg      cfg_we cfg_index cfg_data                     into block
//
//  a load request writes its matrix entry as it is taken; a project request
//  runs three matrix rows of five steps each on the shared multiplier and two
//  31-step serial divisions, which a point behind the near limit skips.
//  in_ready is high only while the sequencer is idle; a finished result waits
//  in the output register while the next request is taken.
//  rst is synchronous; it clears the matrix to zero and the window to 1920x1080.
// ----------------------------------------------------------------------------
module world_to_screen_projection (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                operation,
  input  logic [w2s_pkg::COEF_IW-1:0]         coef_index,
  input  logic signed [w2s_pkg::DATA_W-1:0]   coef_value,
  input  logic signed [w2s_pkg::DATA_W-1:0]   pos_x,
  input  logic signed [w2s_pkg::DATA_W-1:0]   pos_y,
  input  logic signed [w2s_pkg::DATA_W-1:0]   pos_z,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                visible,
  output logic signed [w2s_pkg::DATA_W-1:0]   screen_x,
  output logic signed [w2s_pkg::DATA_W-1:0]   screen_y,
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [w2s_pkg::WIN_W-1:0]           cfg_data
);

  localparam int DW = w2s_pkg::DATA_W;
  localparam int AW = w2s_pkg::ACC_W;
  localparam int HW = w2s_pkg::HALF_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLIP,
    S_CHECK,
    S_DIVX,
    S_DIVY_GO,
    S_DIVY,
    S_SCR0,
    S_SCR1,
    S_SCR2,
    S_SCR3,
    S_OUT
  } state_t;

  state_t                  state;
  logic [1:0]              row;
  logic [2:0]              step;
  logic signed [DW-1:0]    coef [w2s_pkg::COEF_N];
  logic signed [DW-1:0]    px;
  logic signed [DW-1:0]    py;
  logic signed [DW-1:0]    pz;
  logic signed [AW-1:0]    cx;
  logic signed [AW-1:0]    cy;
  logic signed [AW-1:0]    cw;
  logic signed [DW-1:0]    nx;
  logic signed [DW-1:0]    ny;
  logic                    res_vis;
  logic signed [DW-1:0]    res_x;
  logic [w2s_pkg::WIN_W-1:0] window_width;
  logic [w2s_pkg::WIN_W-1:0] window_height;

  w2s_pkg::mac_ctl_t       mac_ctl;
  logic signed [DW-1:0]    mac_a;
  logic signed [DW-1:0]    mac_b;
  logic signed [AW-1:0]    mac_k;
  logic signed [AW-1:0]    acc;

  logic                    div_start;
  logic signed [AW-1:0]    div_num;
  logic signed [AW-1:0]    div_den;
  logic                    div_done;
  logic signed [DW-1:0]    quot;

  logic [HW-1:0]           hw;
  logic [HW-1:0]           hh;
  logic [w2s_pkg::COEF_IW-1:0] rd_idx;
  logic                    out_free;

  assign hw       = window_width[w2s_pkg::WIN_W-1:1];
  assign hh       = window_height[w2s_pkg::WIN_W-1:1];
  assign rd_idx   = {row, step[1:0]};
  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    mac_ctl   = '{mul_en: 1'b0, op: w2s_pkg::ACC_HOLD};
    mac_a     = px;
    mac_b     = coef[rd_idx];
    mac_k     = '0;
    div_start = 1'b0;
    div_num   = cx;
    div_den   = acc;
    case (state)
      S_CLIP: begin
        mac_ctl.mul_en = (step != 3'd4);
        mac_ctl.op     = (step == 3'd0) ? w2s_pkg::ACC_CLEAR : w2s_pkg::ACC_ADD_SHR;
        case (step)
          3'd0:    mac_a = px;
          3'd1:    mac_a = py;
          3'd2:    mac_a = pz;
          default: mac_a = w2s_pkg::ONE_Q;
        endcase
      end
      S_CHECK: begin
        div_start = (acc >= w2s_pkg::THRESH);
      end
      S_DIVY_GO: begin
        div_start = 1'b1;
        div_num   = cy;
        div_den   = cw;
      end
      S_SCR0: begin
        mac_ctl.mul_en = 1'b1;
        mac_a          = nx;
        mac_b          = DW'(hw) + DW'(1);
      end
      S_SCR1: begin
        // screen x = ndcx * (hw + 1) + hw
        mac_ctl.mul_en = 1'b1;
        mac_ctl.op     = w2s_pkg::ACC_LOAD_SUM;
        mac_a          = ny;
        mac_b          = DW'(1) - DW'(hh);
        mac_k          = AW'(hw) << w2s_pkg::FRAC_BITS;
      end
      S_SCR2: begin
        // screen y = ndcy * (1 - hh) + hh
        mac_ctl.op = w2s_pkg::ACC_LOAD_SUM;
        mac_k      = AW'(hh) << w2s_pkg::FRAC_BITS;
      end
      default: begin
      end
    endcase
  end

  w2s_mac u_mac (
    .clk (clk),
    .ctl (mac_ctl),
    .a   (mac_a),
    .b   (mac_b),
    .k   (mac_k),
    .acc (acc)
  );

  w2s_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      window_width  <= w2s_pkg::WIDTH_RST;
      window_height <= w2s_pkg::HEIGHT_RST;
      for (int i = 0; i < w2s_pkg::COEF_N; i++) begin
        coef[w2s_pkg::COEF_IW'(i)] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          w2s_pkg::CFG_WIDTH:  window_width  <= cfg_data;
          w2s_pkg::CFG_HEIGHT: window_height <= cfg_data;
          default: begin
          end
        endcase
      end

      // the output state drives out_valid on its own
      if (out_valid && out_ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (operation == w2s_pkg::OP_LOAD) begin
              coef[coef_index] <= coef_value;
            end else begin
              px    <= pos_x;
              py    <= pos_y;
              pz    <= pos_z;
              row   <= 2'd0;
              step  <= 3'd0;
              state <= S_CLIP;
            end
          end
        end
        S_CLIP: begin
          // previous row result is still in the accumulator during step zero
          if (step == 3'd0 && row == 2'd1) begin
            cx <= acc;
          end
          if (step == 3'd0 && row == 2'd3) begin
            cy <= acc;
          end
          if (step == 3'd4) begin
            step <= 3'd0;
            if (row == 2'd3) begin
              state <= S_CHECK;
            end else begin
              row <= (row == 2'd0) ? 2'd1 : 2'd3;
            end
          end else begin
            step <= step + 3'd1;
          end
        end
        S_CHECK: begin
          cw <= acc;
          if (acc < w2s_pkg::THRESH) begin
            res_vis  <= 1'b0;
            res_x    <= '0;
            screen_y <= screen_y;
            ny       <= '0;
            state    <= S_OUT;
          end else begin
            res_vis <= 1'b1;
            state   <= S_DIVX;
          end
        end
        S_DIVX: begin
          if (div_done) begin
            nx    <= quot;
            state <= S_DIVY_GO;
          end
        end
        S_DIVY_GO: begin
          state <= S_DIVY;
        end
        S_DIVY: begin
          if (div_done) begin
            ny    <= quot;
            state <= S_SCR0;
          end
        end
        S_SCR0: state <= S_SCR1;
        S_SCR1: state <= S_SCR2;
        S_SCR2: begin
          res_x <= w2s_pkg::sat32(acc);
          state <= S_SCR3;
        end
        S_SCR3: begin
          ny    <= w2s_pkg::sat32(acc);
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            visible   <= res_vis;
            screen_x  <= res_x;
            screen_y  <= ny;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives load and project requests into the world to screen projection with
// random idling on both channels. A local fixed point predictor tracks the
// matrix and the window size and checks every screen result in order.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE_CYCLES = 120;
  localparam logic signed [31:0] Q_ONE = 32'sh00010000;
  localparam logic signed [31:0] Q_TOP = 32'sh7FFFFFFF;
  localparam logic signed [31:0] Q_BOTTOM = 32'sh80000000;
  localparam logic signed [63:0] NEAR_W =
    ((64'sd1 <<< w2s_pkg::FRAC_BITS) + 64'sd5) / 64'sd10;

  typedef struct packed {
    logic              op;
    logic [3:0]        idx;
    logic signed [31:0] coef;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
  } request_t;

  typedef struct packed {
    logic              visible;
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
  } screen_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid;
  logic in_ready;
  logic operation;
  logic [w2s_pkg::COEF_IW-1:0] coef_index;
  logic signed [w2s_pkg::DATA_W-1:0] coef_value;
  logic signed [w2s_pkg::DATA_W-1:0] pos_x;
  logic signed [w2s_pkg::DATA_W-1:0] pos_y;
  logic signed [w2s_pkg::DATA_W-1:0] pos_z;
  logic out_valid;
  logic out_ready;
  logic visible;
  logic signed [w2s_pkg::DATA_W-1:0] screen_x;
  logic signed [w2s_pkg::DATA_W-1:0] screen_y;
  logic cfg_we;
  logic cfg_index;
  logic [w2s_pkg::WIN_W-1:0] cfg_data;

  request_t request_q[$];
  screen_t expected_screen_q[$];
  request_t next_req;
  screen_t want;

  logic signed [31:0] coef_model [16];
  logic [13:0] win_w;
  logic [13:0] win_h;

  logic in_took = 1'b0;
  int gap_pct;
  int stall_pct;
  int gap_left = 0;
  int stall_left = 0;
  int mismatch_count = 0;
  int cycle_count = 0;

  world_to_screen_projection uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .coef_index(coef_index), .coef_value(coef_value),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .visible(visible), .screen_x(screen_x), .screen_y(screen_y),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic signed [31:0] clamp_q(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return Q_TOP;
    end else if (v < -64'sd2147483648) begin
      return Q_BOTTOM;
    end
    return v[31:0];
  endfunction

  // one clip coordinate: three floored products plus the translation term
  function automatic logic signed [63:0] clip_coord(input int row,
      input logic signed [31:0] px, input logic signed [31:0] py,
      input logic signed [31:0] pz);
    logic signed [63:0] acc;
    logic signed [63:0] a;
    logic signed [63:0] b;
    int k;
    acc = 0;
    for (k = 0; k < 3; k++) begin
      a = (k == 0) ? px : (k == 1) ? py : pz;
      b = coef_model[4'(row * 4 + k)];
      acc = acc + ((a * b) >>> w2s_pkg::FRAC_BITS);
    end
    b = coef_model[4'(row * 4 + 3)];
    return acc + b;
  endfunction

  // truncating fixed point quotient, den known positive
  function automatic logic signed [31:0] ndc_quotient(input logic signed [63:0] num,
      input logic signed [63:0] den);
    logic neg;
    logic [63:0] mag;
    logic [63:0] dv;
    logic [63:0] quo;
    logic [63:0] rem;
    logic signed [63:0] sq;
    int i;
    neg = (num < 0);
    mag = neg ? -num : num;
    dv = den;
    quo = mag / dv;
    rem = mag % dv;
    if (quo >= (64'd1 << (31 - w2s_pkg::FRAC_BITS))) begin
      quo = 64'd1 << 31;
    end else begin
      for (i = 0; i < w2s_pkg::FRAC_BITS; i++) begin
        rem = rem << 1;
        quo = quo << 1;
        if (rem >= dv) begin
          rem = rem - dv;
          quo[0] = 1'b1;
        end
      end
    end
    sq = neg ? -$signed(quo) : $signed(quo);
    return clamp_q(sq);
  endfunction

  function automatic screen_t project_point(input logic signed [31:0] px,
      input logic signed [31:0] py, input logic signed [31:0] pz);
    screen_t res;
    logic signed [63:0] cx;
    logic signed [63:0] cy;
    logic signed [63:0] cw;
    logic signed [63:0] nx;
    logic signed [63:0] ny;
    logic signed [63:0] half_w;
    logic signed [63:0] half_h;
    cx = clip_coord(0, px, py, pz);
    cy = clip_coord(1, px, py, pz);
    cw = clip_coord(3, px, py, pz);
    res = '0;
    if (cw >= NEAR_W) begin
      nx = ndc_quotient(cx, cw);
      ny = ndc_quotient(cy, cw);
      half_w = win_w >> 1;
      half_h = win_h >> 1;
      res.visible = 1'b1;
      res.screen_x = clamp_q(nx * (half_w + 1) +
                             half_w * (64'sd1 <<< w2s_pkg::FRAC_BITS));
      res.screen_y = clamp_q(ny * (1 - half_h) +
                             half_h * (64'sd1 <<< w2s_pkg::FRAC_BITS));
    end
    return res;
  endfunction

  function automatic logic signed [31:0] rand_coef();
    logic signed [31:0] v;
    case ($urandom_range(0, 9))
      0, 1: v = $urandom;
      2, 3, 4, 5, 6: v = int'($urandom_range(0, 524288)) - 262144;
      7: begin
        case ($urandom_range(0, 4))
          0: v = 0;
          1: v = Q_ONE;
          2: v = -Q_ONE;
          3: v = Q_TOP;
          default: v = Q_BOTTOM;
        endcase
      end
      default: v = int'($urandom_range(0, 33554432)) - 16777216;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] rand_pos();
    logic signed [31:0] v;
    if ($urandom_range(0, 4) == 0) begin
      v = $urandom;
    end else begin
      v = int'($urandom_range(0, 2097152)) - 1048576;
    end
    return v;
  endfunction

  task automatic add_load(input logic [3:0] idx, input logic signed [31:0] val);
    request_t r;
    r.op = w2s_pkg::OP_LOAD;
    r.idx = idx;
    r.coef = val;
    r.px = $urandom;
    r.py = $urandom;
    r.pz = $urandom;
    request_q.push_back(r);
  endtask

  task automatic add_project(input logic signed [31:0] px, input logic signed [31:0] py,
      input logic signed [31:0] pz);
    request_t r;
    r.op = w2s_pkg::OP_PROJECT;
    r.idx = 4'($urandom_range(0, 15));
    r.coef = $urandom;
    r.px = px;
    r.py = py;
    r.pz = pz;
    request_q.push_back(r);
  endtask

  // a usable camera: small w row with a positive constant so most points are visible
  task automatic load_camera();
    int i;
    for (i = 0; i < 16; i++) begin
      if (i == 15) begin
        add_load(4'(i), int'($urandom_range(65536, 4194304)));
      end else if (i >= 12) begin
        add_load(4'(i), int'($urandom_range(0, 32768)) - 16384);
      end else begin
        add_load(4'(i), rand_coef());
      end
    end
  endtask

  task automatic run_random(input int count);
    int k;
    logic [3:0] idx;
    load_camera();
    for (k = 0; k < count; k++) begin
      if ($urandom_range(0, 99) < 75) begin
        add_project(rand_pos(), rand_pos(), rand_pos());
      end else begin
        idx = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) :
                                            4'($urandom_range(0, 11));
        add_load(idx, rand_coef());
      end
    end
  endtask

  task automatic settle();
    @(posedge clk);
    #1;
    while (request_q.size() != 0 || in_valid || expected_screen_q.size() != 0) begin
      @(posedge clk);
      #1;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_window(input logic idx, input logic [13:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == w2s_pkg::CFG_WIDTH) begin
      win_w = val;
    end else begin
      win_h = val;
    end
  endtask

  task automatic set_window(input logic [13:0] w, input logic [13:0] h);
    write_window(w2s_pkg::CFG_WIDTH, w);
    write_window(w2s_pkg::CFG_HEIGHT, h);
  endtask

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else if (!in_valid || in_took) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (request_q.size() > 0) begin
        next_req = request_q.pop_front();
        operation <= next_req.op;
        coef_index <= next_req.idx;
        coef_value <= next_req.coef;
        pos_x <= next_req.px;
        pos_y <= next_req.py;
        pos_z <= next_req.pz;
        in_valid <= 1'b1;
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
          gap_left <= $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        stall_left <= $urandom_range(1, 6);
      end
    end
  end

  // result check first, then the accepted request updates the predictor
  always @(posedge clk) begin
    in_took <= in_valid && in_ready;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_screen_q.size() == 0) begin
          mismatch_count = mismatch_count + 1;
          if (mismatch_count <= 10) begin
            $display("unexpected result: visible %0b x %0d y %0d",
                     visible, screen_x, screen_y);
          end
        end else begin
          want = expected_screen_q.pop_front();
          if (visible !== want.visible || screen_x !== want.screen_x ||
              screen_y !== want.screen_y) begin
            mismatch_count = mismatch_count + 1;
            if (mismatch_count <= 10) begin
              $display("mismatch: expected visible %0b x %0d y %0d, got visible %0b x %0d y %0d",
                       want.visible, want.screen_x, want.screen_y,
                       visible, screen_x, screen_y);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        if (operation == w2s_pkg::OP_LOAD) begin
          coef_model[coef_index] = coef_value;
        end else begin
          expected_screen_q.push_back(project_point(pos_x, pos_y, pos_z));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int i;
    int p;
    cfg_we = 1'b0;
    cfg_index = w2s_pkg::CFG_WIDTH;
    cfg_data = '0;
    gap_pct = 0;
    stall_pct = 0;
    win_w = 14'd1920;
    win_h = 14'd1080;
    for (i = 0; i < 16; i++) begin
      coef_model[4'(i)] = '0;
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed, reset window size
    gap_pct = 20;
    stall_pct = 20;
    add_project(0, 0, 0);                  // zero matrix, w is zero
    add_load(0, Q_ONE);
    add_load(5, Q_ONE);
    add_load(15, Q_ONE);
    add_project(0, 0, 0);                  // screen center
    add_project(Q_ONE, -Q_ONE, Q_TOP);
    add_project(Q_TOP, Q_BOTTOM, Q_TOP);
    add_load(15, NEAR_W[31:0]);            // w right at the near limit
    add_project(Q_TOP, Q_BOTTOM, 0);       // ndc and screen saturate
    add_load(15, NEAR_W[31:0] - 1);        // just below the near limit
    add_project(Q_ONE, Q_ONE, Q_ONE);
    add_load(14, Q_BOTTOM);
    add_load(15, Q_TOP);
    add_project(0, 0, Q_BOTTOM);           // largest product
    add_project(0, 0, Q_TOP);              // w far negative
    add_load(3, Q_TOP);
    add_load(7, Q_BOTTOM);
    add_project(-Q_ONE, Q_ONE, 0);
    add_load(15, -Q_ONE);
    add_load(14, 0);
    add_project(0, 0, 0);                  // negative w
    settle();

    gap_pct = 30;
    stall_pct = 30;
    set_window(14'd1, 14'd1);              // half sizes of zero
    run_random(110);
    settle();

    gap_pct = 0;
    stall_pct = 0;
    set_window(14'h3FFF, 14'h3FFF);
    run_random(110);
    settle();

    gap_pct = 50;
    stall_pct = 20;
    set_window(14'd8192, 14'd0);
    run_random(110);
    settle();

    gap_pct = 10;
    stall_pct = 50;
    set_window(14'd0, 14'd8192);
    run_random(110);
    settle();

    for (p = 0; p < 3; p++) begin
      gap_pct = $urandom_range(0, 50);
      stall_pct = $urandom_range(0, 50);
      set_window(14'($urandom_range(0, 16383)), 14'($urandom_range(0, 16383)));
      run_random(110);
      settle();
    end

    // closing stretch at full rate
    gap_pct = 0;
    stall_pct = 0;
    set_window(14'd1920, 14'd1080);
    run_random(130);
    settle();

    if (mismatch_count == 0 && expected_screen_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/w2s_pkg.sv
hw/rtl/w2s_mac.sv
hw/rtl/w2s_div.sv
hw/rtl/world_to_screen_projection.sv
tb/testbench.sv
